[hdl/tboc_pkg.sv]
// ----------------------------------------------------------------------------
// tboc_pkg
// shared constants, command and status types for the time base offset
// converter
// ----------------------------------------------------------------------------
package tboc_pkg;

	localparam int NUM_BASES     = 8;
	localparam int CELLS         = NUM_BASES * NUM_BASES;
	localparam int IDX_W         = $clog2(NUM_BASES);
	localparam int CELL_W        = $clog2(CELLS);
	localparam int TIME_W        = 64;
	localparam int USEC_PER_MSEC = 1000;
	localparam int USEC_W        = 20;
	localparam logic [USEC_W-1:0] USEC_PER_SEC = USEC_W'(USEC_PER_MSEC * USEC_PER_MSEC);
	localparam int DIV_DIGIT_W   = 8;
	localparam int DIV_STEPS     = TIME_W / DIV_DIGIT_W;
	localparam int DIV_CNT_W     = $clog2(DIV_STEPS);
	localparam int DIV_X_W       = USEC_W + DIV_DIGIT_W;
	localparam int DIV_SHIFT     = DIV_X_W + USEC_W;
	localparam int DIV_RECIP_W   = DIV_X_W + 1;
	localparam int DIV_PROD_W    = DIV_X_W + DIV_RECIP_W;
	// reciprocal of one million, exact for every partial dividend below 2^DIV_X_W
	localparam logic [DIV_RECIP_W-1:0] DIV_RECIP = DIV_RECIP_W'(
		((64'd1 << DIV_SHIFT) + 64'(USEC_PER_MSEC * USEC_PER_MSEC) - 64'd1) /
		64'(USEC_PER_MSEC * USEC_PER_MSEC));

	// controller to datapath
	typedef struct packed {
		logic load;
		logic calc;
		logic wr_ab;
		logic wr_ba;
		logic sw_wr1;
		logic sw_wr2;
		logic sw_next;
		logic cv_add;
		logic cv_abs;
		logic div_est;
		logic div_step;
		logic emit_ok;
		logic emit_fail;
	} tboc_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_convert;
		logic pair_ok;
		logic conv_ok;
		logic need;
		logic sweep_last;
		logic div_last;
	} tboc_sts_t;

	function automatic logic [CELL_W-1:0] cell_idx(input logic [IDX_W-1:0] from,
		input logic [IDX_W-1:0] to);
		return CELL_W'(CELL_W'(from) * CELL_W'(NUM_BASES)) + CELL_W'(to);
	endfunction

endpackage

[hdl/time_base_offset_converter.sv]
// ----------------------------------------------------------------------------
// time_base_offset_converter
// offset table between clock time bases with pair recording, transitive
// closure sweep and time conversion
// ----------------------------------------------------------------------------
// convert: result strobe after check, add, magnitude, eight divider digits of
//   a byte each (estimate, then step) and output; on failure after the check
// add-pair: busy, no result; writes both directions on the shared write port,
//   then the closure sweep tests one triple per cycle, held for filled pairs
// one item at a time; the receiver cannot stall
// reset clears all pair valid bits at once; offsets need no clearing
module time_base_offset_converter import tboc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        mode,
	input  logic [15:0] base_a,
	input  logic [31:0] seconds_a,
	input  logic [19:0] useconds_a,
	input  logic [15:0] base_b,
	input  logic [31:0] seconds_b,
	input  logic [19:0] useconds_b,
	input  logic [7:0]  time_context,
	output logic        done,
	output logic        ok,
	output logic [15:0] out_base,
	output logic [7:0]  out_context,
	output logic [31:0] out_seconds,
	output logic [31:0] out_useconds
);

	tboc_cmd_t cmd;
	tboc_sts_t sts;

	tboc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.sts    (sts)
	);

	tboc_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.mode         (mode),
		.base_a       (base_a),
		.seconds_a    (seconds_a),
		.useconds_a   (useconds_a),
		.base_b       (base_b),
		.seconds_b    (seconds_b),
		.useconds_b   (useconds_b),
		.time_context (time_context),
		.ok           (ok),
		.out_base     (out_base),
		.out_context  (out_context),
		.out_seconds  (out_seconds),
		.out_useconds (out_useconds)
	);

endmodule

[hdl/tboc_dp.sv]
// ----------------------------------------------------------------------------
// tboc_dp
// datapath: input registers, offset memory, pair valid bits, sweep counters,
// offset adder and a byte per step reciprocal divider by one million
// ----------------------------------------------------------------------------
module tboc_dp import tboc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  tboc_cmd_t         cmd,
	output tboc_sts_t         sts,
	input  logic              mode,
	input  logic [15:0]       base_a,
	input  logic [31:0]       seconds_a,
	input  logic [19:0]       useconds_a,
	input  logic [15:0]       base_b,
	input  logic [31:0]       seconds_b,
	input  logic [19:0]       useconds_b,
	input  logic [7:0]        time_context,
	output logic              ok,
	output logic [15:0]       out_base,
	output logic [7:0]        out_context,
	output logic [31:0]       out_seconds,
	output logic [31:0]       out_useconds
);

	logic                 mode_q;
	logic [15:0]          base_a_q, base_b_q;
	logic [31:0]          sec_a_q, sec_b_q;
	logic [19:0]          usec_a_q, usec_b_q;
	logic [7:0]           ctx_q;
	logic [TIME_W-1:0]    ta_q, tb_q;
	logic [TIME_W-1:0]    sum_q;
	logic [TIME_W-1:0]    rd0_q, rd1_q;
	logic [TIME_W-1:0]    offset_mem [CELLS];
	logic [CELLS-1:0]     valid_q;
	logic [IDX_W-1:0]     i_q, j_q, k_q;
	logic [TIME_W-1:0]    dq_q;
	logic [USEC_W-1:0]    rem_q;
	logic [DIV_DIGIT_W-1:0] qd_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 neg_q;
	logic                 ok_q;
	logic [15:0]          out_base_q;
	logic [7:0]           out_ctx_q;
	logic [31:0]          out_sec_q, out_usec_q;

	logic [IDX_W-1:0]     a_idx, b_idx;
	logic                 a_in, b_in;
	logic [CELL_W-1:0]    ab_cell, ba_cell, ij_cell, jk_cell, ik_cell, ki_cell;
	logic [CELL_W-1:0]    rd0_addr, wr_addr;
	logic [TIME_W-1:0]    wr_data;
	logic                 wr_en;
	logic [DIV_X_W-1:0]   div_x, div_r;
	logic [DIV_PROD_W-1:0] div_prod;
	logic                 i_last, j_last, k_last;

	assign a_idx   = base_a_q[IDX_W-1:0];
	assign b_idx   = base_b_q[IDX_W-1:0];
	assign a_in    = base_a_q < 16'(NUM_BASES);
	assign b_in    = base_b_q < 16'(NUM_BASES);
	assign ab_cell = cell_idx(a_idx, b_idx);
	assign ba_cell = cell_idx(b_idx, a_idx);
	assign ij_cell = cell_idx(i_q, j_q);
	assign jk_cell = cell_idx(j_q, k_q);
	assign ik_cell = cell_idx(i_q, k_q);
	assign ki_cell = cell_idx(k_q, i_q);

	assign i_last = i_q == IDX_W'(NUM_BASES - 1);
	assign j_last = j_q == IDX_W'(NUM_BASES - 1);
	assign k_last = k_q == IDX_W'(NUM_BASES - 1);

	assign sts.is_convert = mode_q;
	assign sts.pair_ok    = a_in && b_in;
	assign sts.conv_ok    = a_in && b_in && valid_q[ab_cell];
	assign sts.need       = valid_q[ij_cell] && valid_q[jk_cell] && !valid_q[ik_cell];
	assign sts.sweep_last = i_last && j_last && k_last;
	assign sts.div_last   = cnt_q == DIV_CNT_W'(DIV_STEPS - 1);

	assign rd0_addr = mode_q ? ab_cell : ij_cell;

	always_comb begin
		wr_en   = 1'b1;
		wr_addr = ab_cell;
		wr_data = tb_q - ta_q;
		if (cmd.wr_ba) begin
			wr_addr = ba_cell;
			wr_data = ta_q - tb_q;
		end else if (cmd.sw_wr1) begin
			wr_addr = ik_cell;
			wr_data = rd0_q + rd1_q;
		end else if (cmd.sw_wr2) begin
			wr_addr = ki_cell;
			wr_data = TIME_W'(0) - sum_q;
		end else if (!cmd.wr_ab) begin
			wr_en = 1'b0;
		end
	end

	// offset memory, one write and two registered reads
	always_ff @(posedge clk) begin
		if (wr_en) begin
			offset_mem[wr_addr] <= wr_data;
		end
		rd0_q <= offset_mem[rd0_addr];
		rd1_q <= offset_mem[jk_cell];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			mode_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (cmd.load) begin
				mode_q <= mode;
			end
		end
	end

	// partial dividend: running remainder and the next byte of the magnitude
	assign div_x    = {rem_q, dq_q[TIME_W-1 -: DIV_DIGIT_W]};
	assign div_prod = DIV_PROD_W'(div_x) * DIV_PROD_W'(DIV_RECIP);
	assign div_r    = div_x - DIV_X_W'(qd_q) * DIV_X_W'(USEC_PER_SEC);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			base_a_q <= base_a;
			base_b_q <= base_b;
			sec_a_q  <= seconds_a;
			sec_b_q  <= seconds_b;
			usec_a_q <= useconds_a;
			usec_b_q <= useconds_b;
			ctx_q    <= time_context;
		end
		if (cmd.calc) begin
			ta_q <= TIME_W'(sec_a_q) * TIME_W'(USEC_PER_SEC) + TIME_W'(usec_a_q);
			tb_q <= TIME_W'(sec_b_q) * TIME_W'(USEC_PER_SEC) + TIME_W'(usec_b_q);
		end
		if (cmd.wr_ba) begin
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
		end else if (cmd.sw_next) begin
			if (k_last) begin
				k_q <= '0;
				if (j_last) begin
					j_q <= '0;
					i_q <= i_q + IDX_W'(1);
				end else begin
					j_q <= j_q + IDX_W'(1);
				end
			end else begin
				k_q <= k_q + IDX_W'(1);
			end
		end
		if (cmd.sw_wr1) begin
			sum_q <= rd0_q + rd1_q;
		end else if (cmd.cv_add) begin
			sum_q <= ta_q + rd0_q;
		end
		if (cmd.cv_abs) begin
			neg_q <= sum_q[TIME_W-1];
			dq_q  <= sum_q[TIME_W-1] ? TIME_W'(0) - sum_q : sum_q;
			rem_q <= '0;
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			dq_q  <= {dq_q[TIME_W-DIV_DIGIT_W-1:0], qd_q};
			rem_q <= div_r[USEC_W-1:0];
			cnt_q <= cnt_q + DIV_CNT_W'(1);
		end
		if (cmd.div_est) begin
			qd_q <= div_prod[DIV_SHIFT +: DIV_DIGIT_W];
		end
		if (cmd.emit_ok) begin
			ok_q       <= 1'b1;
			out_base_q <= base_b_q;
			out_ctx_q  <= ctx_q;
			out_sec_q  <= neg_q ? 32'(0) - dq_q[31:0] : dq_q[31:0];
			out_usec_q <= neg_q ? 32'(0) - 32'(rem_q) : 32'(rem_q);
		end else if (cmd.emit_fail) begin
			ok_q       <= 1'b0;
			out_base_q <= '0;
			out_ctx_q  <= '0;
			out_sec_q  <= '0;
			out_usec_q <= '0;
		end
	end

	assign ok           = ok_q;
	assign out_base     = out_base_q;
	assign out_context  = out_ctx_q;
	assign out_seconds  = out_sec_q;
	assign out_useconds = out_usec_q;

	a_wr1_fills_gap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sw_wr1 |-> !valid_q[ik_cell])
		else $error("sweep write to a pair that is already valid");

	a_wr2_after_mark: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sw_wr2 |-> valid_q[ik_cell])
		else $error("reverse write without forward pair marked");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> rem_q < USEC_PER_SEC)
		else $error("divider remainder out of range");

	a_digit_exact: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> div_r < DIV_X_W'(USEC_PER_SEC))
		else $error("divider quotient digit estimate off");

endmodule

[hdl/tboc_ctrl.sv]
// ----------------------------------------------------------------------------
// tboc_ctrl
// controller: sequences add-pair writes, the closure sweep and conversions
// ----------------------------------------------------------------------------
module tboc_ctrl import tboc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	output logic      done,
	output tboc_cmd_t cmd,
	input  tboc_sts_t sts
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CALC,
		ST_PAIR_AB,
		ST_PAIR_BA,
		ST_SW_TEST,
		ST_SW_WR1,
		ST_SW_WR2,
		ST_CV_CHK,
		ST_CV_ADD,
		ST_CV_ABS,
		ST_CV_EST,
		ST_CV_DIV,
		ST_CV_OUT
	} state_t;

	state_t state_q;
	logic   busy_q, done_q;

	always_comb begin
		cmd          = '0;
		cmd.load     = (state_q == ST_IDLE) && start;
		cmd.calc     = state_q == ST_CALC;
		cmd.wr_ab    = state_q == ST_PAIR_AB;
		cmd.wr_ba    = state_q == ST_PAIR_BA;
		cmd.sw_wr1   = state_q == ST_SW_WR1;
		cmd.sw_wr2   = state_q == ST_SW_WR2;
		cmd.sw_next  = ((state_q == ST_SW_TEST) && !sts.need) || (state_q == ST_SW_WR2);
		cmd.cv_add   = state_q == ST_CV_ADD;
		cmd.cv_abs   = state_q == ST_CV_ABS;
		cmd.div_est  = state_q == ST_CV_EST;
		cmd.div_step = state_q == ST_CV_DIV;
		cmd.emit_ok  = state_q == ST_CV_OUT;
		cmd.emit_fail = (state_q == ST_CV_CHK) && !sts.conv_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						busy_q  <= 1'b1;
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					if (sts.is_convert) begin
						state_q <= ST_CV_CHK;
					end else if (sts.pair_ok) begin
						state_q <= ST_PAIR_AB;
					end else begin
						busy_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				ST_PAIR_AB: state_q <= ST_PAIR_BA;
				ST_PAIR_BA: state_q <= ST_SW_TEST;
				ST_SW_TEST: begin
					if (sts.need) begin
						state_q <= ST_SW_WR1;
					end else if (sts.sweep_last) begin
						busy_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				ST_SW_WR1: state_q <= ST_SW_WR2;
				ST_SW_WR2: begin
					if (sts.sweep_last) begin
						busy_q  <= 1'b0;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_SW_TEST;
					end
				end
				ST_CV_CHK: begin
					if (sts.conv_ok) begin
						state_q <= ST_CV_ADD;
					end else begin
						done_q  <= 1'b1;
						busy_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				ST_CV_ADD: state_q <= ST_CV_ABS;
				ST_CV_ABS: state_q <= ST_CV_EST;
				ST_CV_EST: state_q <= ST_CV_DIV;
				ST_CV_DIV: begin
					if (sts.div_last) begin
						state_q <= ST_CV_OUT;
					end else begin
						state_q <= ST_CV_EST;
					end
				end
				ST_CV_OUT: begin
					done_q  <= 1'b1;
					busy_q  <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy = busy_q;
	assign done = done_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while still busy");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("transfer taken without going busy");

	a_wr_pair: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SW_WR1 |=> state_q == ST_SW_WR2)
		else $error("sweep update not completed in both directions");

endmodule

[tb/tboc_conversion_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tboc_conversion_checker
// watches the command and result ports of the time base offset converter,
// keeps its own offset table and pair valid bits, predicts every convert
// result and compares each result transfer field by field
// ----------------------------------------------------------------------------
package tboc_tb_pkg;

	typedef enum logic {
		MODE_PAIR    = 1'b0,
		MODE_CONVERT = 1'b1
	} tboc_mode_e;

endpackage

module tboc_conversion_checker import tboc_pkg::*; import tboc_tb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic        mode,
	input  logic [15:0] base_a,
	input  logic [31:0] seconds_a,
	input  logic [19:0] useconds_a,
	input  logic [15:0] base_b,
	input  logic [31:0] seconds_b,
	input  logic [19:0] useconds_b,
	input  logic [7:0]  time_context,
	input  logic        done,
	input  logic        ok,
	input  logic [15:0] out_base,
	input  logic [7:0]  out_context,
	input  logic [31:0] out_seconds,
	input  logic [31:0] out_useconds,
	output int          mismatches,
	output int          pending
);

	typedef struct packed {
		logic        ok;
		logic [15:0] base;
		logic [7:0]  ctx;
		logic [31:0] secs;
		logic [31:0] usecs;
	} conv_result_t;

	localparam logic [63:0] USEC_PER_SEC_64 = 64'(USEC_PER_SEC);

	logic [63:0]  offset_us [NUM_BASES][NUM_BASES];
	logic         linked [NUM_BASES][NUM_BASES];
	conv_result_t conv_expected [$];
	int           fail_count = 0;
	int           waiting = 0;

	assign mismatches = fail_count;
	assign pending    = waiting;

	function automatic logic [63:0] to_micro(input logic [31:0] secs, input logic [19:0] usecs);
		return 64'(secs) * USEC_PER_SEC_64 + 64'(usecs);
	endfunction

	// stores both directions, then one in-place i,j,k closure sweep
	function automatic void record_pair(input logic [15:0] a16, input logic [15:0] b16,
		input logic [63:0] ta, input logic [63:0] tb);
		int a;
		int b;
		logic [63:0] sum;
		if (a16 >= NUM_BASES || b16 >= NUM_BASES)
			return;
		a = int'(a16);
		b = int'(b16);
		offset_us[a][b] = tb - ta;
		offset_us[b][a] = ta - tb;
		linked[a][b] = 1'b1;
		linked[b][a] = 1'b1;
		for (int i = 0; i < NUM_BASES; i++)
			for (int j = 0; j < NUM_BASES; j++)
				for (int k = 0; k < NUM_BASES; k++)
					if (linked[i][j] && linked[j][k] && !linked[i][k]) begin
						sum = offset_us[i][j] + offset_us[j][k];
						linked[i][k] = 1'b1;
						linked[k][i] = 1'b1;
						offset_us[i][k] = sum;
						offset_us[k][i] = 64'd0 - sum;
					end
	endfunction

	function automatic conv_result_t convert_time(input logic [15:0] from_b,
		input logic [15:0] to_b, input logic [63:0] t_us, input logic [7:0] ctx);
		conv_result_t r;
		logic [63:0] sum;
		logic [63:0] mag;
		logic [63:0] q;
		logic [63:0] rem;
		logic        neg;
		r = '0;
		if (from_b >= NUM_BASES || to_b >= NUM_BASES)
			return r;
		if (!linked[int'(from_b)][int'(to_b)])
			return r;
		sum = t_us + offset_us[int'(from_b)][int'(to_b)];
		neg = sum[63];
		mag = neg ? 64'd0 - sum : sum;
		q   = mag / USEC_PER_SEC_64;
		rem = mag % USEC_PER_SEC_64;
		if (neg) begin
			q   = 64'd0 - q;
			rem = 64'd0 - rem;
		end
		r.ok    = 1'b1;
		r.base  = to_b;
		r.ctx   = ctx;
		r.secs  = q[31:0];
		r.usecs = rem[31:0];
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t: %s", $time, msg);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		conv_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < NUM_BASES; i++)
				for (int j = 0; j < NUM_BASES; j++) begin
					linked[i][j]    = 1'b0;
					offset_us[i][j] = '0;
				end
			conv_expected.delete();
		end else begin
			if (done) begin
				if (conv_expected.size() == 0) begin
					report_mismatch("result transfer with no convert outstanding");
				end else begin
					want = conv_expected.pop_front();
					if (ok !== want.ok)
						report_mismatch($sformatf("ok got %b expected %b", ok, want.ok));
					if (out_base !== want.base)
						report_mismatch($sformatf("out_base got %0d expected %0d",
							out_base, want.base));
					if (out_context !== want.ctx)
						report_mismatch($sformatf("out_context got %0h expected %0h",
							out_context, want.ctx));
					if (out_seconds !== want.secs)
						report_mismatch($sformatf("out_seconds got %0h expected %0h",
							out_seconds, want.secs));
					if (out_useconds !== want.usecs)
						report_mismatch($sformatf("out_useconds got %0h expected %0h",
							out_useconds, want.usecs));
				end
			end
			if (start && !busy) begin
				if (mode == MODE_CONVERT)
					conv_expected.push_back(convert_time(base_a, base_b,
						to_micro(seconds_a, useconds_a), time_context));
				else
					record_pair(base_a, base_b, to_micro(seconds_a, useconds_a),
						to_micro(seconds_b, useconds_b));
			end
		end
		waiting = conv_expected.size();
	end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the time base offset converter: directed pair and
// convert commands on an empty and partly linked table, then random commands
// under three sender idle profiles, checked by tboc_conversion_checker
// ----------------------------------------------------------------------------
module tb import tboc_pkg::*; import tboc_tb_pkg::*;;

	localparam int SETTLE_CYCLES   = 4 + NUM_BASES ** 3 + 2 * CELLS;
	localparam int MAX_GAP         = 700;
	localparam int STALL_LIMIT     = 4 * (SETTLE_CYCLES + MAX_GAP);
	localparam int ITEMS_PER_PHASE = 390;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        start        = 1'b0;
	logic        mode         = MODE_PAIR;
	logic [15:0] base_a       = '0;
	logic [31:0] seconds_a    = '0;
	logic [19:0] useconds_a   = '0;
	logic [15:0] base_b       = '0;
	logic [31:0] seconds_b    = '0;
	logic [19:0] useconds_b   = '0;
	logic [7:0]  time_context = '0;
	logic        busy;
	logic        done;
	logic        ok;
	logic [15:0] out_base;
	logic [7:0]  out_context;
	logic [31:0] out_seconds;
	logic [31:0] out_useconds;
	int          mismatches;
	int          pending;
	int          quiet_cycles = 0;

	time_base_offset_converter u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.mode         (mode),
		.base_a       (base_a),
		.seconds_a    (seconds_a),
		.useconds_a   (useconds_a),
		.base_b       (base_b),
		.seconds_b    (seconds_b),
		.useconds_b   (useconds_b),
		.time_context (time_context),
		.done         (done),
		.ok           (ok),
		.out_base     (out_base),
		.out_context  (out_context),
		.out_seconds  (out_seconds),
		.out_useconds (out_useconds)
	);

	tboc_conversion_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.mode         (mode),
		.base_a       (base_a),
		.seconds_a    (seconds_a),
		.useconds_a   (useconds_a),
		.base_b       (base_b),
		.seconds_b    (seconds_b),
		.useconds_b   (useconds_b),
		.time_context (time_context),
		.done         (done),
		.ok           (ok),
		.out_base     (out_base),
		.out_context  (out_context),
		.out_seconds  (out_seconds),
		.out_useconds (out_useconds),
		.mismatches   (mismatches),
		.pending      (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic issue(input logic m, input logic [15:0] ba, input logic [31:0] sa,
		input logic [19:0] ua, input logic [15:0] bb, input logic [31:0] sb,
		input logic [19:0] ub, input logic [7:0] ctx);
		bit taken;
		start        <= 1'b1;
		mode         <= m;
		base_a       <= ba;
		seconds_a    <= sa;
		useconds_a   <= ua;
		base_b       <= bb;
		seconds_b    <= sb;
		useconds_b   <= ub;
		time_context <= ctx;
		do begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end while (!taken);
	endtask

	task automatic sender_gap(input int pct);
		int len;
		if ($urandom_range(99) < pct) begin
			len = $urandom_range(1, ($urandom_range(3) == 0) ? MAX_GAP : 80);
			start <= 1'b0;
			repeat (len) @(posedge clk);
		end
	endtask

	// hold off until the block is idle and every convert result has come back
	task automatic drain();
		bit idle;
		start <= 1'b0;
		do begin
			@(negedge clk);
			idle = (pending == 0) && !busy;
			@(posedge clk);
		end while (!idle);
	endtask

	function automatic logic [15:0] pick_base();
		case ($urandom_range(19))
			0:       return 16'hFFFF;
			1:       return 16'(NUM_BASES);
			2:       return 16'($urandom_range(NUM_BASES, 16'hFFFF));
			default: return 16'($urandom_range(NUM_BASES - 1));
		endcase
	endfunction

	function automatic logic [31:0] pick_seconds();
		case ($urandom_range(9))
			0:       return 32'd0;
			1:       return 32'hFFFF_FFFF;
			2:       return 32'($urandom_range(1000));
			default: return 32'($urandom);
		endcase
	endfunction

	function automatic logic [19:0] pick_useconds();
		case ($urandom_range(9))
			0:       return 20'd0;
			1:       return 20'hFFFFF;
			2:       return 20'd999999;
			3:       return 20'($urandom_range(20'hFFFFF));
			default: return 20'($urandom_range(999999));
		endcase
	endfunction

	initial begin : stimulus
		int          counted;
		logic        m;
		logic [15:0] ba;
		logic [15:0] bb;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table and out-of-range bases
		issue(MODE_CONVERT, 16'd0, 32'd1, 20'd2, 16'd1, 32'd0, 20'd0, 8'hA5);
		issue(MODE_CONVERT, 16'hFFFF, 32'd1, 20'd2, 16'd0, 32'd0, 20'd0, 8'h5A);
		issue(MODE_CONVERT, 16'd0, 32'd1, 20'd2, 16'd8, 32'd0, 20'd0, 8'h01);
		issue(MODE_PAIR, 16'd8, 32'd1, 20'd2, 16'd0, 32'd3, 20'd4, 8'h00);
		issue(MODE_PAIR, 16'd1, 32'd1, 20'd2, 16'hFFFF, 32'd3, 20'd4, 8'h00);
		issue(MODE_CONVERT, 16'd1, 32'd1, 20'd2, 16'd0, 32'd0, 20'd0, 8'h02);
		// same base twice
		issue(MODE_PAIR, 16'd3, 32'd0, 20'd0, 16'd3, 32'd5, 20'd17, 8'h00);
		issue(MODE_CONVERT, 16'd3, 32'd9, 20'd999999, 16'd3, 32'd0, 20'd0, 8'hFF);
		// large negative offset and negative sums
		issue(MODE_PAIR, 16'd0, 32'hFFFF_FFFF, 20'd999999, 16'd1, 32'd0, 20'd0, 8'h00);
		issue(MODE_CONVERT, 16'd0, 32'd0, 20'd0, 16'd1, 32'd0, 20'd0, 8'h11);
		issue(MODE_CONVERT, 16'd0, 32'd12, 20'hFFFFF, 16'd1, 32'hFFFF_FFFF, 20'hFFFFF, 8'h22);
		issue(MODE_CONVERT, 16'd1, 32'hFFFF_FFFF, 20'hFFFFF, 16'd0, 32'd0, 20'd0, 8'h33);
		// two-hop closure and disjoint groups
		issue(MODE_PAIR, 16'd1, 32'd100, 20'd250000, 16'd2, 32'd40, 20'd750000, 8'h00);
		issue(MODE_CONVERT, 16'd0, 32'd7, 20'd1, 16'd2, 32'd0, 20'd0, 8'h44);
		issue(MODE_CONVERT, 16'd2, 32'd7, 20'd1, 16'd0, 32'd0, 20'd0, 8'h55);
		issue(MODE_CONVERT, 16'd0, 32'd7, 20'd1, 16'd7, 32'd0, 20'd0, 8'h66);
		issue(MODE_PAIR, 16'd7, 32'd5000, 20'd3, 16'd6, 32'd10, 20'd999999, 8'h00);
		issue(MODE_CONVERT, 16'd6, 32'd0, 20'd0, 16'd7, 32'd0, 20'd0, 8'hFF);
		issue(MODE_CONVERT, 16'd6, 32'd1, 20'd0, 16'd0, 32'd0, 20'd0, 8'h77);
		issue(MODE_PAIR, 16'd2, 32'd0, 20'd0, 16'd6, 32'hFFFF_FFFF, 20'hFFFFF, 8'h00);
		issue(MODE_CONVERT, 16'd7, 32'd0, 20'd0, 16'd0, 32'd0, 20'd0, 8'h88);
		issue(MODE_CONVERT, 16'd0, 32'hFFFF_FFFF, 20'hFFFFF, 16'd7, 32'd0, 20'd0, 8'h99);
		issue(MODE_CONVERT, 16'd3, 32'd4, 20'd4, 16'd0, 32'd0, 20'd0, 8'hAA);
		drain();

		for (int phase = 0; phase < 3; phase++) begin
			counted = 0;
			while (counted < ITEMS_PER_PHASE) begin
				m  = ($urandom_range(3) == 0) ? MODE_PAIR : MODE_CONVERT;
				ba = pick_base();
				bb = pick_base();
				counted++;
				sender_gap(phase == 0 ? 8 : (phase == 1 ? 74 : 0));
				issue(m, ba, pick_seconds(), pick_useconds(), bb, pick_seconds(),
					pick_useconds(), 8'($urandom_range(255)));
			end
			drain();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
